// ===== sv/drnl_pkg.sv =====
// ----------------------------------------------------------------------------
// drnl_pkg
// Shared types and constants of the directory record name lookup.
// ----------------------------------------------------------------------------
package drnl_pkg;

   localparam int SECTOR_SIZE = 2048;
   localparam int SECTOR_W    = $clog2(SECTOR_SIZE);
   localparam int NAME_MAX    = 32;
   localparam int NAME_BYTES  = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [1:0] {
      MODE_LENGTH,
      MODE_RECORD,
      MODE_SKIP,
      MODE_DONE
   } mode_type;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_NAME_LEN = 3'd0;
   localparam csr_idx_type CSR_NAME_W0  = 3'd1;
   localparam csr_idx_type CSR_NAME_W1  = 3'd2;
   localparam csr_idx_type CSR_NAME_W2  = 3'd3;
   localparam csr_idx_type CSR_NAME_W3  = 3'd4;

   typedef struct packed {
      logic [5:0]                target_len;
      logic [NAME_BYTES*8-1:0]   name;
   } cfg_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  entry_flags;
      logic [31:0] entry_size;
      logic [31:0] entry_address;
   } rsp_type;

endpackage

// ===== sv/drnl_req_if.sv =====
// ----------------------------------------------------------------------------
// drnl_req_if
// Request channel: one directory byte per transfer.
// ----------------------------------------------------------------------------
interface drnl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] dir_byte;
   logic       last_byte;

   modport source (output valid, dir_byte, last_byte, input ready);
   modport sink   (input valid, dir_byte, last_byte, output ready);
endinterface

// ===== sv/drnl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// drnl_rsp_if
// Response channel: lookup result.
// ----------------------------------------------------------------------------
interface drnl_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [7:0]  entry_flags;
   logic [31:0] entry_size;
   logic [31:0] entry_address;

   modport source (output valid, found, entry_flags, entry_size, entry_address,
                   input ready);
   modport sink   (input valid, found, entry_flags, entry_size, entry_address,
                   output ready);
endinterface

// ===== sv/drnl_csr_if.sv =====
// ----------------------------------------------------------------------------
// drnl_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface drnl_csr_if;
   logic                        valid;
   logic                        ready;
   logic [drnl_pkg::CSR_IDX_W-1:0]  index;
   logic [drnl_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/drnl_csr.sv =====
// ----------------------------------------------------------------------------
// drnl_csr
// Target name registers, written through the register channel.
// ----------------------------------------------------------------------------
module drnl_csr (
   input  logic              clock,
   input  logic              reset,
   drnl_csr_if.sink          csr_bus,
   output drnl_pkg::cfg_type cfg
);
   import drnl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_NAME_LEN: cfg_in.target_len    = csr_bus.data[5:0];
            CSR_NAME_W0:  cfg_in.name[63:0]    = csr_bus.data;
            CSR_NAME_W1:  cfg_in.name[127:64]  = csr_bus.data;
            CSR_NAME_W2:  cfg_in.name[191:128] = csr_bus.data;
            CSR_NAME_W3:  cfg_in.name[255:192] = csr_bus.data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_len <= 6'd1;
         cfg_ff.name       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/drnl_parse.sv =====
// ----------------------------------------------------------------------------
// drnl_parse
// Per-byte directory record parser and name comparator.
// ----------------------------------------------------------------------------
module drnl_parse #(
   parameter int MAX_SECTORS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        dir_byte,
   input  logic              last_byte,
   input  drnl_pkg::cfg_type cfg,
   output logic              emit,
   output drnl_pkg::rsp_type result
);
   import drnl_pkg::*;

   localparam int DIR_BYTES = SECTOR_SIZE * MAX_SECTORS;
   localparam int OFS_W     = $clog2(DIR_BYTES + 1);
   localparam logic [OFS_W-1:0] DIR_END = OFS_W'(DIR_BYTES);

   localparam logic [7:0] POS_ADDR0  = 8'd2;
   localparam logic [7:0] POS_ADDR1  = 8'd3;
   localparam logic [7:0] POS_ADDR2  = 8'd4;
   localparam logic [7:0] POS_ADDR3  = 8'd5;
   localparam logic [7:0] POS_SIZE0  = 8'd10;
   localparam logic [7:0] POS_SIZE1  = 8'd11;
   localparam logic [7:0] POS_SIZE2  = 8'd12;
   localparam logic [7:0] POS_SIZE3  = 8'd13;
   localparam logic [7:0] POS_FLAGS  = 8'd25;
   localparam logic [7:0] POS_NAMLEN = 8'd32;
   localparam logic [7:0] POS_NAME   = 8'd33;

   logic [OFS_W-1:0] ofs_ff,      ofs_in;
   logic [7:0]       pos_ff,      pos_in;
   logic [7:0]       len_ff,      len_in;
   mode_type         mode_ff,     mode_in;
   logic [31:0]      addr_ff,     addr_in;
   logic [31:0]      size_ff,     size_in;
   logic [7:0]       flags_ff,    flags_in;
   logic [7:0]       rnl_ff,      rnl_in;
   logic             mismatch_ff, mismatch_in;

   logic       match;
   logic [7:0] pos_n;
   logic [7:0] name_idx;
   logic [7:0] name_byte;

   assign pos_n     = pos_ff + 8'd1;
   assign name_idx  = pos_n - POS_NAME;
   assign name_byte = cfg.name[{name_idx[4:0], 3'b000} +: 8];

   always_comb begin
      ofs_in      = ofs_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      mode_in     = mode_ff;
      addr_in     = addr_ff;
      size_in     = size_ff;
      flags_in    = flags_ff;
      rnl_in      = rnl_ff;
      mismatch_in = mismatch_ff;
      match       = 1'b0;

      if (mode_ff != MODE_DONE && ofs_ff < DIR_END) begin
         case (mode_ff)
            MODE_LENGTH: begin
               if (dir_byte == 8'd0) begin
                  mode_in = MODE_SKIP;
               end else begin
                  len_in      = dir_byte;
                  pos_in      = 8'd0;
                  addr_in     = '0;
                  size_in     = '0;
                  flags_in    = '0;
                  rnl_in      = '0;
                  mismatch_in = 1'b0;
                  mode_in     = (dir_byte == 8'd1) ? MODE_LENGTH : MODE_RECORD;
               end
            end
            MODE_RECORD: begin
               pos_in = pos_n;
               case (pos_n)
                  POS_ADDR0: addr_in[7:0]   = addr_ff[7:0]   | dir_byte;
                  POS_ADDR1: addr_in[15:8]  = addr_ff[15:8]  | dir_byte;
                  POS_ADDR2: addr_in[23:16] = addr_ff[23:16] | dir_byte;
                  POS_ADDR3: addr_in[31:24] = addr_ff[31:24] | dir_byte;
                  POS_SIZE0: size_in[7:0]   = size_ff[7:0]   | dir_byte;
                  POS_SIZE1: size_in[15:8]  = size_ff[15:8]  | dir_byte;
                  POS_SIZE2: size_in[23:16] = size_ff[23:16] | dir_byte;
                  POS_SIZE3: size_in[31:24] = size_ff[31:24] | dir_byte;
                  POS_FLAGS: flags_in       = dir_byte;
                  POS_NAMLEN: begin
                     rnl_in = dir_byte;
                     if (dir_byte != {2'b00, cfg.target_len} ||
                         {1'b0, cfg.target_len} > 7'(NAME_MAX)) begin
                        mismatch_in = 1'b1;
                     end else if (dir_byte == 8'd0) begin
                        match = 1'b1;
                     end
                  end
                  default: begin
                     if (pos_n >= POS_NAME && !mismatch_ff && name_idx < rnl_ff) begin
                        if (dir_byte != name_byte) begin
                           mismatch_in = 1'b1;
                        end else if ({1'b0, name_idx} + 9'd1 == {1'b0, rnl_ff}) begin
                           match = 1'b1;
                        end
                     end
                  end
               endcase
               if (match) begin
                  mode_in = MODE_DONE;
               end else if ({1'b0, pos_n} + 9'd1 >= {1'b0, len_ff}) begin
                  mode_in = MODE_LENGTH;
               end
            end
            default: mode_in = mode_ff;
         endcase
         ofs_in = ofs_ff + OFS_W'(1);
         // padding ends at the sector boundary
         if (mode_in == MODE_SKIP && ofs_in[SECTOR_W-1:0] == '0) begin
            mode_in = MODE_LENGTH;
         end
      end

      emit = accept && (match || (last_byte && mode_in != MODE_DONE));
      if (match) begin
         result.found         = 1'b1;
         result.entry_flags   = flags_ff;
         result.entry_size    = size_ff;
         result.entry_address = addr_ff;
      end else begin
         result.found         = 1'b0;
         result.entry_flags   = 8'hFF;
         result.entry_size    = '1;
         result.entry_address = '0;
      end

      // restart for the next directory
      if (last_byte) begin
         ofs_in      = '0;
         pos_in      = '0;
         len_in      = '0;
         mode_in     = MODE_LENGTH;
         addr_in     = '0;
         size_in     = '0;
         flags_in    = '0;
         rnl_in      = '0;
         mismatch_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ofs_ff      <= '0;
         pos_ff      <= '0;
         len_ff      <= '0;
         mode_ff     <= MODE_LENGTH;
         addr_ff     <= '0;
         size_ff     <= '0;
         flags_ff    <= '0;
         rnl_ff      <= '0;
         mismatch_ff <= 1'b0;
      end else if (accept) begin
         ofs_ff      <= ofs_in;
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         mode_ff     <= mode_in;
         addr_ff     <= addr_in;
         size_ff     <= size_in;
         flags_ff    <= flags_in;
         rnl_ff      <= rnl_in;
         mismatch_ff <= mismatch_in;
      end
   end

endmodule

// ===== sv/drnl_outq.sv =====
// ----------------------------------------------------------------------------
// drnl_outq
// Result register with a skid stage in front of the response channel.
// ----------------------------------------------------------------------------
module drnl_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  drnl_pkg::rsp_type push_data,
   output logic              space,
   drnl_rsp_if.source        rsp_bus
);
   import drnl_pkg::*;

   logic    out_valid_ff,  out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff,        out_in;
   rsp_type skid_ff,       skid_in;
   logic    pop;

   assign pop   = out_valid_ff && rsp_bus.ready;
   assign space = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = push_data;
            out_valid_in = push;
         end
      end else if (push) begin
         // hold the head, park the new result
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.found         = out_ff.found;
   assign rsp_bus.entry_flags   = out_ff.entry_flags;
   assign rsp_bus.entry_size    = out_ff.entry_size;
   assign rsp_bus.entry_address = out_ff.entry_address;

endmodule

// ===== sv/directory_record_name_lookup.sv =====
// ----------------------------------------------------------------------------
// directory_record_name_lookup
// Walks the records of a CD directory extent and looks up a name.
// ----------------------------------------------------------------------------
// Usage:
//   csr_bus writes the target name: index 0 its length, indexes 1..4 the name
//   bytes eight at a time. Write it only while no lookup is in flight.
//   req_bus carries the directory one byte per request, last_byte set on the
//   final byte. One request is taken every cycle while req_bus.ready is high;
//   the per-byte parse is a single registered step.
//   rsp_bus gives one result per directory: found with the record's flags,
//   size and extent address on the byte that completes the match, or
//   not-found on the last byte. The result is registered before rsp_bus.
//   Bytes after a match are dropped until last_byte.
//   A result register and a skid stage sit before rsp_bus; with both full,
//   req_bus.ready drops until the receiver takes a result.
//   Reset clears the parser and the result queue and loads a target length
//   of one with all name bytes zero. Parsing stops after MAX_SECTORS sectors.
// ----------------------------------------------------------------------------
module directory_record_name_lookup #(
   parameter int MAX_SECTORS = 4
) (
   input  logic         clock,
   input  logic         reset,
   drnl_req_if.sink     req_bus,
   drnl_rsp_if.source   rsp_bus,
   drnl_csr_if.sink     csr_bus
);
   import drnl_pkg::*;

   cfg_type cfg;
   rsp_type result;
   logic    emit;
   logic    space;
   logic    accept;

   assign req_bus.ready = space;
   assign accept        = req_bus.valid && space;

   drnl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   drnl_parse #(
      .MAX_SECTORS (MAX_SECTORS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .dir_byte  (req_bus.dir_byte),
      .last_byte (req_bus.last_byte),
      .cfg       (cfg),
      .emit      (emit),
      .result    (result)
   );

   drnl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (result),
      .space     (space),
      .rsp_bus   (rsp_bus)
   );

endmodule
